### sv/ldar_pkg.sv
`default_nettype none

package ldar_pkg;

    localparam int LEVEL_W  = 8;
    localparam int DUR_W    = 21;
    localparam int CYCLES_W = 20;
    localparam int STEP_W   = 16;
    localparam int PORT_W   = 8;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd182;
    localparam logic [DUR_W-1:0]  DUR_MAX    = {DUR_W{1'b1}};

    // input command codes
    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // register index taken from paddr[2]
    localparam logic REG_STEP_IDX = 1'b0;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [DUR_W-1:0]   dur;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // result of one sample beat: where the single ring write goes and what it holds
    typedef struct packed {
        logic   advance;   // write at next(read) and move the read index there
        entry_t wdata;
    } sample_upd_t;

endpackage

`default_nettype wire

### sv/ldar_ram.sv
`default_nettype none

module ldar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr_a,
    output logic      [WIDTH-1:0]  rdata_a,
    input  wire logic [ADDR_W-1:0] raddr_b,
    output logic      [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word when the same address is written on that edge
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

### sv/ldar_sample_calc.sv
`default_nettype none

module ldar_sample_calc
    import ldar_pkg::*;
(
    input  wire entry_t              cur_entry,
    input  wire entry_t              nxt_entry,
    input  wire logic [STEP_W-1:0]   step,
    input  wire logic                next_is_write,
    output sample_upd_t              upd
);

    logic [DUR_W-1:0] step_ext;
    logic [DUR_W:0]   sum;

    assign step_ext = {{(DUR_W-STEP_W){1'b0}}, step};
    assign sum      = {1'b0, nxt_entry.dur} + {1'b0, cur_entry.dur};

    always_comb
    begin
        upd.advance = 1'b0;
        upd.wdata   = cur_entry;
        if (cur_entry.dur > step_ext)
        begin
            upd.wdata.dur = cur_entry.dur - step_ext;
        end
        else if (next_is_write)
        begin
            // ring empty: leftover goes back into the cleared entry
            upd.wdata.level = '0;
            upd.wdata.dur   = cur_entry.dur;
        end
        else
        begin
            // the cleared entry is left stale: it is rewritten by a record before
            // the read index can come back to it
            upd.advance     = 1'b1;
            upd.wdata.level = nxt_entry.level;
            upd.wdata.dur   = sum[DUR_W] ? DUR_MAX : sum[DUR_W-1:0];
        end
    end

endmodule

`default_nettype wire

### sv/level_duration_audio_resampler.sv
`default_nettype none

// level/duration audio resampler
// input channel (in_valid/in_stall) carries one beat per port event (cmd record)
// or per audio sample request (cmd sample). a record beat stores one ring entry
// and returns nothing; a sample beat returns one sample_out beat on the output
// channel (out_valid/out_stall), in request order.
// an accepted beat sits in the item register, where a record always retires;
// a sample retires once the ring ram saw no write in the previous cycle, since
// the ram read is registered, and once the output register is free. a new beat
// is taken as the last retires; the result shows up the cycle after retirement.
// the next beat is taken while a finished sample waits in the output register.
// a stalled receiver holds the output register; a sample that finds it full
// waits in the item register and stalls the input.
// after reset a clearing pass writes zero to all RING_DEPTH entries, one per
// cycle, with in_stall high; step_cycles resets to 182 and may be written
// through the apb port at any time (byte address 0).
module level_duration_audio_resampler
    import ldar_pkg::*;
#(
    parameter int RING_DEPTH = 1024
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [APB_AW-1:0]   paddr,
    input  wire logic [APB_DW-1:0]   pwdata,
    output logic      [APB_DW-1:0]   prdata,
    output logic                     pready,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                cmd,
    input  wire logic [PORT_W-1:0]   port_value,
    input  wire logic [LEVEL_W-1:0]  tape,
    input  wire logic [CYCLES_W-1:0] cycles,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic      [LEVEL_W-1:0]  sample_out
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
        ring_next = (i == IDX_LAST) ? '0 : i + 1'b1;
    endfunction

    logic [STEP_W-1:0]   step_reg;
    logic                clr_active_reg;
    logic [IDX_W-1:0]    clr_addr_reg;
    logic [IDX_W-1:0]    wr_idx_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [PORT_W-1:0]   prev_port_reg;
    logic                fresh_reg;
    logic                item_valid_reg;
    logic                item_cmd_reg;
    logic [PORT_W-1:0]   item_port_reg;
    logic [LEVEL_W-1:0]  item_tape_reg;
    logic [CYCLES_W-1:0] item_cycles_reg;
    logic                out_valid_reg;
    logic [LEVEL_W-1:0]  sample_reg;

    logic                cfg_write;
    logic                accept;
    logic                out_free;
    logic                do_record;
    logic                do_sample;
    logic                item_done;
    logic [IDX_W-1:0]    rd_idx_nxt;
    logic [IDX_W-1:0]    wr_idx_nxt;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    entry_t              mem_wdata;
    entry_t              cur_entry;
    entry_t              nxt_entry;
    entry_t              rec_entry;
    sample_upd_t         upd;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = (paddr[2] == REG_STEP_IDX) ?
                       {{(APB_DW-STEP_W){1'b0}}, step_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
        end
        else if (cfg_write && paddr[2] == REG_STEP_IDX)
        begin
            step_reg <= pwdata[STEP_W-1:0];
        end
    end

    // ring memory, read ports always follow the read index and its successor
    assign rd_idx_nxt = ring_next(rd_idx_reg);
    assign wr_idx_nxt = ring_next(wr_idx_reg);

    ldar_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (rd_idx_reg),
        .rdata_a (cur_entry),
        .raddr_b (rd_idx_nxt),
        .rdata_b (nxt_entry)
    );

    ldar_sample_calc u_calc (
        .cur_entry     (cur_entry),
        .nxt_entry     (nxt_entry),
        .step          (step_reg),
        .next_is_write (rd_idx_nxt == wr_idx_reg),
        .upd           (upd)
    );

    // retire logic for the beat in the item register
    assign out_free  = ~out_valid_reg | ~out_stall;
    assign do_record = item_valid_reg & (item_cmd_reg == CMD_RECORD);
    assign do_sample = item_valid_reg & (item_cmd_reg == CMD_SAMPLE) & fresh_reg & out_free;
    assign item_done = do_record | do_sample;
    assign in_stall  = clr_active_reg | (item_valid_reg & ~item_done);
    assign accept    = in_valid & ~in_stall;

    assign rec_entry.level = {prev_port_reg[LEVEL_W-3:0], 2'b00} + item_tape_reg;
    assign rec_entry.dur   = {{(DUR_W-CYCLES_W){1'b0}}, item_cycles_reg};

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr_idx_reg;
        mem_wdata = rec_entry;
        if (clr_active_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else if (do_record)
        begin
            mem_we = 1'b1;
        end
        else if (do_sample)
        begin
            mem_we    = 1'b1;
            mem_waddr = upd.advance ? rd_idx_nxt : rd_idx_reg;
            mem_wdata = upd.wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            wr_idx_reg     <= '0;
            rd_idx_reg     <= '0;
            prev_port_reg  <= '0;
            fresh_reg      <= 1'b0;
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= ring_next(clr_addr_reg);
                if (clr_addr_reg == IDX_LAST)
                begin
                    clr_active_reg <= 1'b0;
                end
            end

            // read data is trustworthy only after an edge with no ram write
            fresh_reg <= ~mem_we;

            if (accept)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (item_done)
            begin
                item_valid_reg <= 1'b0;
            end

            if (do_record)
            begin
                prev_port_reg <= item_port_reg;
                if (wr_idx_nxt != rd_idx_reg)
                begin
                    wr_idx_reg <= wr_idx_nxt;
                end
            end

            if (do_sample && upd.advance)
            begin
                rd_idx_reg <= rd_idx_nxt;
            end

            if (do_sample)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_cmd_reg    <= cmd;
            item_port_reg   <= port_value;
            item_tape_reg   <= tape;
            item_cycles_reg <= cycles;
        end
        if (do_sample)
        begin
            sample_reg <= cur_entry.level;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_reg;

endmodule

`default_nettype wire

### test/level_duration_audio_resampler_tb.sv
`timescale 1ns / 100ps

module level_duration_audio_resampler_tb
    import ldar_pkg::*;
();

    localparam int RING       = 1024;
    localparam int IDLE_LIMIT = 6000;
    localparam logic [APB_AW-1:0] STEP_ADDR  = {REG_STEP_IDX, 2'b00};
    localparam logic [APB_AW-1:0] SPARE_ADDR = {~REG_STEP_IDX, 2'b00};

    typedef struct packed {
        logic                cmd;
        logic [PORT_W-1:0]   port;
        logic [LEVEL_W-1:0]  tape;
        logic [CYCLES_W-1:0] cyc;
        logic                typed;   // level below is the one to expect
        logic [LEVEL_W-1:0]  level;
    } beat_t;

    localparam int NPLAN = 20;
    localparam beat_t PLAN [NPLAN] = '{
        {CMD_RECORD, 8'hff, 8'h00, 20'h00000, 1'b0, 8'h00},
        // ring empty right away: read index stays on the cleared entry
        {CMD_SAMPLE, 8'hff, 8'hff, 20'hfffff, 1'b1, 8'h00},
        {CMD_RECORD, 8'h3f, 8'hff, 20'h000b6, 1'b0, 8'h00},
        {CMD_SAMPLE, 8'h00, 8'h00, 20'h00000, 1'b1, 8'h00},
        // duration equal to the step, leftover goes back to the same entry
        {CMD_SAMPLE, 8'h00, 8'h00, 20'h00000, 1'b1, 8'hfb},
        {CMD_SAMPLE, 8'haa, 8'h55, 20'h55555, 1'b0, 8'h00},
        {CMD_RECORD, 8'h00, 8'h80, 20'h000b7, 1'b0, 8'h00},
        {CMD_RECORD, 8'h55, 8'h01, 20'h00001, 1'b0, 8'h00},
        {CMD_RECORD, 8'haa, 8'h7f, 20'h00000, 1'b0, 8'h00},
        {CMD_SAMPLE, 8'h55, 8'haa, 20'haaaaa, 1'b0, 8'h00},
        {CMD_SAMPLE, 8'h00, 8'h00, 20'h00000, 1'b0, 8'h00},
        {CMD_SAMPLE, 8'h00, 8'h00, 20'h00000, 1'b0, 8'h00},
        {CMD_SAMPLE, 8'hff, 8'hff, 20'hfffff, 1'b0, 8'h00},
        {CMD_SAMPLE, 8'h00, 8'h00, 20'h00000, 1'b0, 8'h00},
        {CMD_SAMPLE, 8'h00, 8'h00, 20'h00000, 1'b0, 8'h00},
        {CMD_RECORD, 8'h00, 8'hfe, 20'haaaaa, 1'b0, 8'h00},
        {CMD_RECORD, 8'h7f, 8'h00, 20'h55555, 1'b0, 8'h00},
        {CMD_RECORD, 8'h80, 8'h55, 20'hfffff, 1'b0, 8'h00},
        {CMD_SAMPLE, 8'h00, 8'h00, 20'h00000, 1'b0, 8'h00},
        {CMD_SAMPLE, 8'h00, 8'h00, 20'h00000, 1'b0, 8'h00}
    };

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [APB_AW-1:0]   paddr      = '0;
    logic [APB_DW-1:0]   pwdata     = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                in_valid   = 1'b0;
    logic                in_stall;
    logic                cmd        = CMD_RECORD;
    logic [PORT_W-1:0]   port_value = '0;
    logic [LEVEL_W-1:0]  tape       = '0;
    logic [CYCLES_W-1:0] cycles     = '0;
    logic                out_valid;
    logic                out_stall  = 1'b0;
    logic [LEVEL_W-1:0]  sample_out;

    // mirror of the block state
    logic [LEVEL_W-1:0]  level_mirror [RING];
    logic [DUR_W-1:0]    dur_mirror   [RING];
    int unsigned         wr_ptr;
    int unsigned         rd_ptr;
    logic [PORT_W-1:0]   last_port;
    logic [STEP_W-1:0]   step_now;

    logic [LEVEL_W-1:0]  pending_samples [$];
    logic [LEVEL_W-1:0]  want_level;
    int                  mismatches = 0;
    bit                  calm       = 1'b0;

    level_duration_audio_resampler #(
        .RING_DEPTH(RING)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .port_value (port_value),
        .tape       (tape),
        .cycles     (cycles),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

    always #2 clk = ~clk;

    function automatic int unsigned ring_next(input int unsigned idx);
        return (idx + 1 >= RING) ? 0 : idx + 1;
    endfunction

    task automatic resample(input beat_t b, output bit emits, output logic [LEVEL_W-1:0] lvl);
        int unsigned       nxt;
        logic [DUR_W-1:0]  left;
        logic [DUR_W:0]    sum;
        emits = 1'b0;
        lvl   = '0;
        if (b.cmd == CMD_RECORD)
        begin
            level_mirror[wr_ptr] = {last_port[5:0], 2'b00} + b.tape;
            dur_mirror[wr_ptr]   = DUR_W'(b.cyc);
            nxt = ring_next(wr_ptr);
            // full ring: stay put, next record overwrites this entry
            if (nxt != rd_ptr)
                wr_ptr = nxt;
            last_port = b.port;
        end
        else
        begin
            emits = 1'b1;
            lvl   = level_mirror[rd_ptr];
            left  = dur_mirror[rd_ptr];
            if (left > DUR_W'(step_now))
            begin
                dur_mirror[rd_ptr] = left - DUR_W'(step_now);
            end
            else
            begin
                level_mirror[rd_ptr] = '0;
                dur_mirror[rd_ptr]   = '0;
                nxt = ring_next(rd_ptr);
                if (nxt != wr_ptr)
                    rd_ptr = nxt;
                sum = {1'b0, dur_mirror[rd_ptr]} + {1'b0, left};
                dur_mirror[rd_ptr] = sum[DUR_W] ? DUR_MAX : sum[DUR_W-1:0];
            end
        end
    endtask

    // starts and ends at a falling edge
    task automatic push_beat(input beat_t b);
        bit                 emits;
        logic [LEVEL_W-1:0] lvl;
        while (!calm && $urandom_range(99) < 27)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        cmd        = b.cmd;
        port_value = b.port;
        tape       = b.tape;
        cycles     = b.cyc;
        do @(posedge clk); while (in_stall);
        resample(b, emits, lvl);
        if (emits)
            pending_samples.push_back(b.typed ? b.level : lvl);
        @(negedge clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] data, output logic [APB_DW-1:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        if (wr && addr[2] == REG_STEP_IDX)
            step_now = data[STEP_W-1:0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic check_step();
        logic [APB_DW-1:0] rd;
        apb_xfer(1'b0, STEP_ADDR, '0, rd);
        if (rd[STEP_W-1:0] !== step_now)
        begin
            mismatches++;
            $display("[%0t] step_cycles readback: expected %0d, got %0d",
                     $time, step_now, rd[STEP_W-1:0]);
        end
    endtask

    task automatic set_step(input logic [STEP_W-1:0] val);
        logic [APB_DW-1:0] rd;
        // upper data bits are junk the register must drop
        apb_xfer(1'b1, STEP_ADDR, {16'($urandom), val}, rd);
        if ($urandom_range(1) == 1)
            apb_xfer(1'b1, SPARE_ADDR, $urandom, rd);
        check_step();
    endtask

    // records return nothing, so give the last one time to retire
    task automatic wait_quiet();
        in_valid = 1'b0;
        while (pending_samples.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic logic [CYCLES_W-1:0] pick_cycles();
        int unsigned roll;
        roll = $urandom_range(99);
        if (step_now == 0)
            return (roll < 60) ? '0 : CYCLES_W'($urandom_range(3, 1));
        if (roll < 25)
            return CYCLES_W'($urandom_range(3));
        if (roll < 30 && step_now >= 16384)
            return CYCLES_W'($urandom);
        return CYCLES_W'($urandom_range(2 * step_now + 1));
    endfunction

    function automatic beat_t random_beat(input int unsigned record_pct);
        beat_t b;
        b.cmd   = ($urandom_range(99) < record_pct) ? CMD_RECORD : CMD_SAMPLE;
        b.port  = PORT_W'($urandom);
        b.tape  = LEVEL_W'($urandom);
        b.cyc   = pick_cycles();
        b.typed = 1'b0;
        b.level = '0;
        return b;
    endfunction

    always @(negedge clk)
        out_stall = !calm && ($urandom_range(99) < 27);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_samples.size() == 0)
            begin
                mismatches++;
                $display("[%0t] sample_out: expected nothing, got %02h", $time, sample_out);
            end
            else
            begin
                want_level = pending_samples.pop_front();
                if (sample_out !== want_level)
                begin
                    mismatches++;
                    $display("[%0t] sample_out: expected %02h, got %02h",
                             $time, want_level, sample_out);
                end
            end
        end
    end

    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("level_duration_audio_resampler verification failed");
        $finish;
    end

    initial
    begin
        logic [STEP_W-1:0] seg_step;
        int unsigned       seg_pct;
        int unsigned       seg_len;
        for (int i = 0; i < RING; i++)
        begin
            level_mirror[i] = '0;
            dur_mirror[i]   = '0;
        end
        wr_ptr    = 0;
        rd_ptr    = 0;
        last_port = '0;
        step_now  = STEP_RESET;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        check_step();

        for (int i = 0; i < NPLAN; i++)
            push_beat(PLAN[i]);

        for (int seg = 0; seg < 9; seg++)
        begin
            wait_quiet();
            calm    = 1'b0;
            seg_len = 105;
            case (seg)
                // fill to full
                0:
                begin
                    seg_step = 16'hffff;
                    seg_pct  = 100;
                    seg_len  = 1040;
                end
                1:
                begin
                    seg_step = 16'd0;
                    seg_pct  = 50;
                end
                2:
                begin
                    seg_step = 16'd1;
                    seg_pct  = 20;
                end
                3:
                begin
                    seg_step = 16'd182;
                    seg_pct  = 50;
                    calm     = 1'b1;
                end
                4:
                begin
                    seg_step = 16'hffff;
                    seg_pct  = 20;
                end
                default:
                begin
                    seg_step = ($urandom_range(1) == 1) ? STEP_W'($urandom_range(400, 2))
                                                        : STEP_W'($urandom_range(65534, 2));
                    seg_pct  = (seg % 3 == 0) ? 80 : ((seg % 3 == 1) ? 50 : 20);
                end
            endcase
            set_step(seg_step);
            for (int n = 0; n < seg_len; n++)
                push_beat(random_beat(seg_pct));
        end

        in_valid = 1'b0;
        calm     = 1'b0;
        while (pending_samples.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
        if (mismatches == 0)
            $display("level_duration_audio_resampler verification clean");
        else
            $display("level_duration_audio_resampler verification failed");
        $finish;
    end

endmodule

### files.f
sv/ldar_pkg.sv
sv/ldar_ram.sv
sv/ldar_sample_calc.sv
sv/level_duration_audio_resampler.sv
test/level_duration_audio_resampler_tb.sv
